// ===== hw/rtl/crcdf_pkg.sv =====
package crcdf_pkg;

  localparam logic [7:0]  MAGIC_A  = 8'hAA;
  localparam logic [7:0]  MAGIC_B  = 8'h55;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int NUM_CODES = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int IDX_W     = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_AUDIO      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_SET_PARAM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_GET_STATUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_ACK        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_STATUS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_SPECTRUM   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_MAX       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECTRUM_MAX    = 3'd7;

  // event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_BODY    = 3'd1;
  localparam logic [2:0] EV_CRC_OK  = 3'd2;
  localparam logic [2:0] EV_CRC_BAD = 3'd3;
  localparam logic [2:0] EV_ABORT   = 3'd4;

  typedef enum logic [2:0] {
    K_AUDIO,
    K_SET,
    K_GET,
    K_ACK,
    K_STATUS,
    K_SPEC,
    K_NONE
  } kind_e;

  typedef struct packed {
    logic [NUM_CODES-1:0][7:0] code;
    logic [15:0]               audio_max;
    logic [15:0]               spectrum_max;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       event_res;
    logic [7:0]       frame_type;
    logic [IDX_W-1:0] body_index;
    logic [7:0]       body_byte;
    logic             in_frame;
  } res_t;

  // first match wins, lowest index first
  function automatic kind_e kind_of(cfg_t c, logic [7:0] t);
    kind_e k;
    k = K_NONE;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if (c.code[i] == t) begin
        k = kind_e'(3'(i));
      end
    end
    return k;
  endfunction

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/crcdf_cfg_regs.sv =====
module crcdf_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [crcdf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [crcdf_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  output crcdf_pkg::cfg_t                     cfg_o
);

  crcdf_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        crcdf_pkg::CFG_CODE_AUDIO:      cfg_d.code[0] = cfg_data_i[7:0];
        crcdf_pkg::CFG_CODE_SET_PARAM:  cfg_d.code[1] = cfg_data_i[7:0];
        crcdf_pkg::CFG_CODE_GET_STATUS: cfg_d.code[2] = cfg_data_i[7:0];
        crcdf_pkg::CFG_CODE_ACK:        cfg_d.code[3] = cfg_data_i[7:0];
        crcdf_pkg::CFG_CODE_STATUS:     cfg_d.code[4] = cfg_data_i[7:0];
        crcdf_pkg::CFG_CODE_SPECTRUM:   cfg_d.code[5] = cfg_data_i[7:0];
        crcdf_pkg::CFG_AUDIO_MAX:       cfg_d.audio_max = cfg_data_i;
        crcdf_pkg::CFG_SPECTRUM_MAX:    cfg_d.spectrum_max = cfg_data_i;
        default:                        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code[0]      <= 8'd1;
      cfg_q.code[1]      <= 8'd2;
      cfg_q.code[2]      <= 8'd3;
      cfg_q.code[3]      <= 8'd4;
      cfg_q.code[4]      <= 8'd5;
      cfg_q.code[5]      <= 8'd6;
      cfg_q.audio_max    <= 16'd1024;
      cfg_q.spectrum_max <= 16'd128;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/crcdf_parser.sv =====
module crcdf_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_i,
  input  crcdf_pkg::cfg_t   cfg_i,
  output crcdf_pkg::res_t   res_o
);

  localparam int W = crcdf_pkg::IDX_W;

  localparam logic [2:0] PH_MAGIC0 = 3'd0;
  localparam logic [2:0] PH_MAGIC1 = 3'd1;
  localparam logic [2:0] PH_TYPE   = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_CRC0   = 3'd4;
  localparam logic [2:0] PH_CRC1   = 3'd5;

  logic [2:0]   phase_q, phase_d;
  logic [7:0]   type_q, type_d;
  logic [W-1:0] have_q, have_d;
  logic [W-1:0] need_q, need_d;
  logic         added_q, added_d;
  logic [15:0]  crc_q, crc_d;
  logic [7:0]   crc_lo_q, crc_lo_d;
  logic [7:0]   len_lo_q, len_lo_d;

  crcdf_pkg::kind_e kind;
  logic             clr;
  logic [15:0]      len;
  logic [15:0]      cap;
  logic [2:0]       ev;
  logic [7:0]       ft;
  logic [W-1:0]     idx;
  logic [7:0]       bb;

  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    have_d   = have_q;
    need_d   = need_q;
    added_d  = added_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    len_lo_d = len_lo_q;
    clr      = 1'b0;
    ev       = crcdf_pkg::EV_NONE;
    ft       = 8'd0;
    idx      = '0;
    bb       = 8'd0;
    len      = {data_i, len_lo_q};
    kind     = crcdf_pkg::kind_of(cfg_i, (phase_q == PH_TYPE) ? data_i : type_q);
    cap      = (kind == crcdf_pkg::K_AUDIO) ? cfg_i.audio_max : cfg_i.spectrum_max;

    case (phase_q)
      PH_MAGIC0: begin
        if (data_i == crcdf_pkg::MAGIC_A) phase_d = PH_MAGIC1;
      end
      PH_MAGIC1: begin
        if (data_i == crcdf_pkg::MAGIC_B) begin
          phase_d = PH_TYPE;
        end else if (data_i != crcdf_pkg::MAGIC_A) begin
          phase_d = PH_MAGIC0;
        end
      end
      PH_TYPE: begin
        if (kind == crcdf_pkg::K_NONE) begin
          phase_d = (data_i == crcdf_pkg::MAGIC_A) ? PH_MAGIC1 : PH_MAGIC0;
        end else begin
          type_d  = data_i;
          crc_d   = crcdf_pkg::crc_byte(crcdf_pkg::CRC_INIT, data_i);
          have_d  = '0;
          added_d = 1'b0;
          case (kind)
            crcdf_pkg::K_SET:    need_d = W'(5);
            crcdf_pkg::K_GET:    need_d = '0;
            crcdf_pkg::K_ACK:    need_d = W'(2);
            crcdf_pkg::K_STATUS: need_d = W'(14);
            default:             need_d = W'(3);
          endcase
          phase_d = (need_d == '0) ? PH_CRC0 : PH_BODY;
        end
      end
      PH_BODY: begin
        crc_d = crcdf_pkg::crc_byte(crc_q, data_i);
        if (!added_q && have_q == W'(1)) len_lo_d = data_i;
        if ((kind == crcdf_pkg::K_AUDIO || kind == crcdf_pkg::K_SPEC) &&
            !added_q && have_q == W'(2)) begin
          if (len == 16'd0 || len > cap) begin
            clr = 1'b1;
            ev  = crcdf_pkg::EV_ABORT;
            ft  = type_q;
          end else begin
            added_d = 1'b1;
            need_d  = need_q + W'(len);
          end
        end
        if (!clr) begin
          ev     = crcdf_pkg::EV_BODY;
          idx    = have_q;
          bb     = data_i;
          have_d = have_q + W'(1);
          if (have_d == need_d) phase_d = PH_CRC0;
        end
      end
      PH_CRC0: begin
        crc_lo_d = data_i;
        phase_d  = PH_CRC1;
      end
      PH_CRC1: begin
        ev  = ({data_i, crc_lo_q} == crc_q) ? crcdf_pkg::EV_CRC_OK : crcdf_pkg::EV_CRC_BAD;
        ft  = type_q;
        clr = 1'b1;
      end
      default: clr = 1'b1;
    endcase

    if (clr) begin
      phase_d  = PH_MAGIC0;
      type_d   = 8'd0;
      have_d   = '0;
      need_d   = '0;
      added_d  = 1'b0;
      crc_d    = crcdf_pkg::CRC_INIT;
      crc_lo_d = 8'd0;
      len_lo_d = 8'd0;
    end

    if (ev == crcdf_pkg::EV_NONE || ev == crcdf_pkg::EV_BODY) ft = type_d;

    res_o.event_res  = ev;
    res_o.frame_type = ft;
    res_o.body_index = idx;
    res_o.body_byte  = bb;
    res_o.in_frame   = (phase_d != PH_MAGIC0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC0;
      type_q   <= 8'd0;
      have_q   <= '0;
      need_q   <= '0;
      added_q  <= 1'b0;
      crc_q    <= crcdf_pkg::CRC_INIT;
      crc_lo_q <= 8'd0;
      len_lo_q <= 8'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      have_q   <= have_d;
      need_q   <= need_d;
      added_q  <= added_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      len_lo_q <= len_lo_d;
    end
  end

endmodule

// ===== hw/rtl/crc_checked_frame_deframer.sv =====
// path: an accepted byte reaches its result word at the outputs through the
//   input register and the result register
// throughput: one byte per cycle while the output is not stalled; the parse and crc
//   update lie between the input register and the result register
// reset: asynchronous, active low; the parser returns to magic hunting with the
//   crc at ffff and the configuration registers take their default values
module crc_checked_frame_deframer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          data_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          event_res_o,
  output logic [7:0]                          frame_type_o,
  output logic [crcdf_pkg::IDX_W-1:0]         body_index_o,
  output logic [7:0]                          body_byte_o,
  output logic                                in_frame_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [crcdf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [crcdf_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  crcdf_pkg::cfg_t cfg;
  crcdf_pkg::res_t res;
  crcdf_pkg::res_t res_q;

  logic       in_v_q, in_v_d;
  logic [7:0] in_byte_q;
  logic       out_v_q, out_v_d;
  logic       advance;
  logic       accept;

  assign advance    = in_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o = in_v_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_v_d = in_v_q;
    if (accept) begin
      in_v_d = 1'b1;
    end else if (advance) begin
      in_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (advance) begin
      out_v_d = 1'b1;
    end else if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_byte_q <= data_byte_i;
    if (advance) res_q <= res;
  end

  crcdf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  crcdf_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .data_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o  = out_v_q;
  assign event_res_o  = res_q.event_res;
  assign frame_type_o = res_q.frame_type;
  assign body_index_o = res_q.body_index;
  assign body_byte_o  = res_q.body_byte;
  assign in_frame_o   = res_q.in_frame;

endmodule

// ===== tb/crc_checked_frame_deframer_tb.sv =====
module crc_checked_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    HUNT_A,
    HUNT_B,
    TYPE_BYTE,
    BODY,
    CRC_LO,
    CRC_HI
  } parse_e;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic [7:0]                      data_byte_i = 8'h00;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [2:0]                      event_res_o;
  logic [7:0]                      frame_type_o;
  logic [crcdf_pkg::IDX_W-1:0]     body_index_o;
  logic [7:0]                      body_byte_o;
  logic                            in_frame_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [crcdf_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [crcdf_pkg::CFG_DAT_W-1:0] cfg_data_i  = '0;

  crc_checked_frame_deframer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_res_o  (event_res_o),
    .frame_type_o (frame_type_o),
    .body_index_o (body_index_o),
    .body_byte_o  (body_byte_o),
    .in_frame_o   (in_frame_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // configuration as the parser should see it
  logic [7:0]  type_code [crcdf_pkg::NUM_CODES];
  logic [15:0] audio_cap;
  logic [15:0] spec_cap;

  // parser state
  parse_e       pr_phase;
  logic [7:0]   pr_type;
  logic [16:0]  pr_have;
  logic [16:0]  pr_need;
  logic         pr_len_taken;
  logic [15:0]  pr_crc;
  logic [7:0]   pr_crc_lo;
  logic [7:0]   pr_len_lo;

  logic [7:0]      rx_stream [$];
  logic [7:0]      frame_buf [$];
  crcdf_pkg::res_t predicted_events [$];
  crcdf_pkg::res_t want_w;

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int bytes_queued = 0;
  int bytes_taken  = 0;
  int words_checked = 0;
  int mismatches   = 0;
  int frames_good  = 0;
  int frames_bad   = 0;
  int frames_cut   = 0;
  int cfg_sets     = 0;

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? crcdf_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic crcdf_pkg::kind_e match_kind(input logic [7:0] t);
    crcdf_pkg::kind_e k;
    k = crcdf_pkg::K_NONE;
    for (int i = 0; i < crcdf_pkg::NUM_CODES; i++) begin
      if (k == crcdf_pkg::K_NONE && type_code[i] == t) begin
        k = crcdf_pkg::kind_e'(3'(i));
      end
    end
    return k;
  endfunction

  // body bytes known from the type alone; variable kinds carry seq and length
  function automatic int body_base(input crcdf_pkg::kind_e k);
    case (k)
      crcdf_pkg::K_SET:    return 5;
      crcdf_pkg::K_GET:    return 0;
      crcdf_pkg::K_ACK:    return 2;
      crcdf_pkg::K_STATUS: return 14;
      default:             return 3;
    endcase
  endfunction

  task automatic clear_parser();
    pr_phase     = HUNT_A;
    pr_type      = 8'h00;
    pr_have      = '0;
    pr_need      = '0;
    pr_len_taken = 1'b0;
    pr_crc       = crcdf_pkg::CRC_INIT;
    pr_crc_lo    = 8'h00;
    pr_len_lo    = 8'h00;
  endtask

  task automatic track_byte(input logic [7:0] b);
    crcdf_pkg::res_t  r;
    crcdf_pkg::kind_e k;
    logic [15:0]      len;
    logic [15:0]      cap;
    bit               aborted;
    r = '0;
    aborted = 1'b0;
    case (pr_phase)
      HUNT_A: begin
        if (b == crcdf_pkg::MAGIC_A) pr_phase = HUNT_B;
      end
      HUNT_B: begin
        if (b == crcdf_pkg::MAGIC_B) pr_phase = TYPE_BYTE;
        else if (b != crcdf_pkg::MAGIC_A) pr_phase = HUNT_A;
      end
      TYPE_BYTE: begin
        k = match_kind(b);
        if (k == crcdf_pkg::K_NONE) begin
          pr_phase = (b == crcdf_pkg::MAGIC_A) ? HUNT_B : HUNT_A;
        end else begin
          pr_type      = b;
          pr_crc       = crc16_step(crcdf_pkg::CRC_INIT, b);
          pr_have      = '0;
          pr_len_taken = 1'b0;
          pr_need      = 17'(body_base(k));
          pr_phase     = (pr_need == 17'd0) ? CRC_LO : BODY;
        end
      end
      BODY: begin
        k = match_kind(pr_type);
        pr_crc = crc16_step(pr_crc, b);
        if (!pr_len_taken && pr_have == 17'd1) pr_len_lo = b;
        if ((k == crcdf_pkg::K_AUDIO || k == crcdf_pkg::K_SPEC) && !pr_len_taken &&
            pr_have == 17'd2) begin
          len = {b, pr_len_lo};
          cap = (k == crcdf_pkg::K_AUDIO) ? audio_cap : spec_cap;
          if (len == 16'd0 || len > cap) begin
            r.event_res  = crcdf_pkg::EV_ABORT;
            r.frame_type = pr_type;
            clear_parser();
            aborted = 1'b1;
          end else begin
            pr_len_taken = 1'b1;
            pr_need      = pr_need + 17'(len);
          end
        end
        if (!aborted) begin
          r.event_res  = crcdf_pkg::EV_BODY;
          r.body_index = pr_have;
          r.body_byte  = b;
          pr_have      = pr_have + 17'd1;
          if (pr_have == pr_need) pr_phase = CRC_LO;
        end
      end
      CRC_LO: begin
        pr_crc_lo = b;
        pr_phase  = CRC_HI;
      end
      CRC_HI: begin
        r.event_res  = ({b, pr_crc_lo} == pr_crc) ? crcdf_pkg::EV_CRC_OK
                                                  : crcdf_pkg::EV_CRC_BAD;
        r.frame_type = pr_type;
        clear_parser();
      end
      default: clear_parser();
    endcase
    if (r.event_res == crcdf_pkg::EV_NONE || r.event_res == crcdf_pkg::EV_BODY)
      r.frame_type = pr_type;
    r.in_frame = (pr_phase != HUNT_A);
    predicted_events.push_back(r);
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endtask

  task automatic emit_frame(input logic [7:0] t, input logic [15:0] err,
                            input bit extra_magic, input bit with_crc);
    logic [15:0] c;
    push_byte(crcdf_pkg::MAGIC_A);
    if (extra_magic) push_byte(crcdf_pkg::MAGIC_A);
    push_byte(crcdf_pkg::MAGIC_B);
    push_byte(t);
    c = crc16_step(crcdf_pkg::CRC_INIT, t);
    foreach (frame_buf[i]) begin
      push_byte(frame_buf[i]);
      c = crc16_step(c, frame_buf[i]);
    end
    if (with_crc) begin
      c = c ^ err;
      push_byte(c[7:0]);
      push_byte(c[15:8]);
    end
    frame_buf.delete();
  endtask

  task automatic gen_traffic(input int target);
    int               start;
    int               pick;
    int               n;
    int               len;
    int               cap;
    int               keep;
    logic [7:0]       t;
    crcdf_pkg::kind_e k;
    logic [15:0]      err;
    bit               cut;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        n = $urandom_range(5, 1);
        repeat (n) begin
          case ($urandom_range(3))
            0:       push_byte(crcdf_pkg::MAGIC_A);
            1:       push_byte(crcdf_pkg::MAGIC_B);
            default: push_byte(8'($urandom_range(255)));
          endcase
        end
      end else begin
        if ($urandom_range(99) < 8) t = 8'($urandom_range(255));
        else t = type_code[$urandom_range(crcdf_pkg::NUM_CODES - 1)];
        k = match_kind(t);
        frame_buf.delete();
        n = 0;
        if (k == crcdf_pkg::K_AUDIO || k == crcdf_pkg::K_SPEC) begin
          cap  = (k == crcdf_pkg::K_AUDIO) ? audio_cap : spec_cap;
          pick = $urandom_range(99);
          if (pick < 80) len = $urandom_range((cap < 24) ? cap : 24, 1);
          else if (pick < 87) len = (cap <= 300) ? cap : $urandom_range(24, 1);
          else if (pick < 93) len = 0;
          else len = (cap < 65535) ? cap + 1 : 0;
          frame_buf.push_back(8'($urandom_range(255)));
          frame_buf.push_back(8'(len));
          frame_buf.push_back(8'(len >> 8));
          n = (len == 0 || len > cap) ? 0 : len;
        end else if (k != crcdf_pkg::K_NONE) begin
          n = body_base(k);
        end
        repeat (n) frame_buf.push_back(8'($urandom_range(255)));
        cut = (k != crcdf_pkg::K_NONE) && (frame_buf.size() > 0) &&
              ($urandom_range(99) < 5);
        if (cut) begin
          keep = $urandom_range(frame_buf.size() - 1, 0);
          while (frame_buf.size() > keep) void'(frame_buf.pop_back());
        end
        err = ($urandom_range(99) < 15) ? 16'($urandom_range(65535, 1)) : 16'h0000;
        emit_frame(t, err, $urandom_range(99) < 20, (k != crcdf_pkg::K_NONE) && !cut);
      end
    end
  endtask

  task automatic put_reg(input logic [crcdf_pkg::CFG_IDX_W-1:0] idx,
                         input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == crcdf_pkg::CFG_AUDIO_MAX) audio_cap = val;
    else if (idx == crcdf_pkg::CFG_SPECTRUM_MAX) spec_cap = val;
    else type_code[idx] = val[7:0];
  endtask

  task automatic apply_cfg(input logic [7:0] c_audio, input logic [7:0] c_set,
                           input logic [7:0] c_get, input logic [7:0] c_ack,
                           input logic [7:0] c_status, input logic [7:0] c_spec,
                           input logic [15:0] a_cap, input logic [15:0] s_cap);
    put_reg(crcdf_pkg::CFG_CODE_AUDIO, {8'h00, c_audio});
    put_reg(crcdf_pkg::CFG_CODE_SET_PARAM, {8'h00, c_set});
    put_reg(crcdf_pkg::CFG_CODE_GET_STATUS, {8'h00, c_get});
    put_reg(crcdf_pkg::CFG_CODE_ACK, {8'h00, c_ack});
    put_reg(crcdf_pkg::CFG_CODE_STATUS, {8'h00, c_status});
    put_reg(crcdf_pkg::CFG_CODE_SPECTRUM, {8'h00, c_spec});
    put_reg(crcdf_pkg::CFG_AUDIO_MAX, a_cap);
    put_reg(crcdf_pkg::CFG_SPECTRUM_MAX, s_cap);
    cfg_valid_i <= 1'b0;
    cfg_sets++;
  endtask

  task automatic drain();
    while (words_checked != bytes_queued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void check_field(input string what, input logic [16:0] want,
                                      input logic [16:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 200)
        $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    end
  endfunction

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= 8'h00;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        track_byte(data_byte_i);
        bytes_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (rx_stream.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid_i  <= 1'b1;
          data_byte_i <= rx_stream.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 200)
            $display("%0t: word with nothing expected, event %0d", $time, event_res_o);
        end else begin
          want_w = predicted_events.pop_front();
          check_field("event_res", 17'(want_w.event_res), 17'(event_res_o));
          check_field("frame_type", 17'(want_w.frame_type), 17'(frame_type_o));
          check_field("body_index", want_w.body_index, body_index_o);
          check_field("body_byte", 17'(want_w.body_byte), 17'(body_byte_o));
          check_field("in_frame", 17'(want_w.in_frame), 17'(in_frame_o));
          case (want_w.event_res)
            crcdf_pkg::EV_CRC_OK:  frames_good++;
            crcdf_pkg::EV_CRC_BAD: frames_bad++;
            crcdf_pkg::EV_ABORT:   frames_cut++;
            default: ;
          endcase
          words_checked++;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    for (int i = 0; i < crcdf_pkg::NUM_CODES; i++) type_code[i] = 8'(i + 1);
    audio_cap = 16'd1024;
    spec_cap  = 16'd128;
    clear_parser();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults, no gaps
    emit_frame(type_code[crcdf_pkg::K_GET], 16'h0000, 1'b1, 1'b1);
    push_byte(crcdf_pkg::MAGIC_A);
    push_byte(crcdf_pkg::MAGIC_B);
    frame_buf.push_back(8'h11);
    frame_buf.push_back(8'h22);
    emit_frame(type_code[crcdf_pkg::K_ACK], 16'h0101, 1'b0, 1'b1);
    frame_buf.push_back(8'h9C);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    emit_frame(type_code[crcdf_pkg::K_AUDIO], 16'h0000, 1'b0, 1'b0);
    frame_buf.push_back(8'h01);
    frame_buf.push_back(8'h81);
    frame_buf.push_back(8'h00);
    emit_frame(type_code[crcdf_pkg::K_SPEC], 16'h0000, 1'b0, 1'b0);
    gen_traffic(170);
    drain();

    apply_cfg(8'h00, 8'hFF, 8'h30, 8'h55, 8'h80, 8'h7F, 16'd1, 16'd65535);
    send_gap_pct = 51;
    stall_pct    = 0;
    gen_traffic(170);
    drain();

    // colliding codes: audio beats spectrum, set_param beats ack
    apply_cfg(8'h10, 8'h20, 8'hAA, 8'h20, 8'h40, 8'h10, 16'd37, 16'd9);
    send_gap_pct = 0;
    stall_pct    = 51;
    gen_traffic(170);
    drain();

    apply_cfg(8'hC3, 8'h3C, 8'h00, 8'h0F, 8'hF0, 8'h5A, 16'd300, 16'd2);
    send_gap_pct = 23;
    stall_pct    = 23;
    gen_traffic(170);
    drain();

    apply_cfg(8'hA5, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF, 16'd65535, 16'd65535);
    send_gap_pct = 0;
    stall_pct    = 0;
    gen_traffic(170);
    drain();

    if (predicted_events.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected words never arrived", $time, predicted_events.size());
    end
    $display("%0d bytes through %0d register sets, %0d result words checked",
             bytes_taken, cfg_sets + 1, words_checked);
    $display("frames ended: %0d crc good, %0d crc bad, %0d bad length; %0d mismatches",
             frames_good, frames_bad, frames_cut, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
